FILE: design/rbc_kin_pkg.sv
// Shared types and constants for the rotating bar chain kinematics unit.
`timescale 1ns / 1ps

package rbc_kin_pkg;

  // Operation codes of an input word
  localparam logic OpLoad = 1'b0;
  localparam logic OpTick = 1'b1;

  // Rotation CORDIC set-up: iteration count and gain-compensated start value
  localparam int unsigned CordicSteps = 14;
  localparam logic signed [18:0] CordicStart = 19'sd39797;

  // Rounding offset for the 16-bit right shift of each length product
  localparam logic signed [41:0] RoundHalf = 42'sd32768;

  // Highest even bit position of the square root search (radicand below 2^40)
  localparam logic [39:0] RootTop = 40'h40_0000_0000;

  // Sequencer states, one-hot
  typedef enum logic [10:0] {
    ST_IDLE = 11'b000_0000_0001,
    ST_PREP = 11'b000_0000_0010,
    ST_ROT  = 11'b000_0000_0100,
    ST_MULC = 11'b000_0000_1000,
    ST_MULS = 11'b000_0001_0000,
    ST_ACCS = 11'b000_0010_0000,
    ST_SQX  = 11'b000_0100_0000,
    ST_SQY  = 11'b000_1000_0000,
    ST_SQS  = 11'b001_0000_0000,
    ST_ROOT = 11'b010_0000_0000,
    ST_EMIT = 11'b100_0000_0000
  } state_e;

  // Arctangent of 2^-i in 1/65536-turn units
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] v;
    case (i)
      4'd0:    v = 14'd8192;
      4'd1:    v = 14'd4836;
      4'd2:    v = 14'd2555;
      4'd3:    v = 14'd1297;
      4'd4:    v = 14'd651;
      4'd5:    v = 14'd326;
      4'd6:    v = 14'd163;
      4'd7:    v = 14'd81;
      4'd8:    v = 14'd41;
      4'd9:    v = 14'd20;
      4'd10:   v = 14'd10;
      4'd11:   v = 14'd5;
      4'd12:   v = 14'd3;
      4'd13:   v = 14'd1;
      default: v = 14'd0;
    endcase
    return v;
  endfunction

endpackage

FILE: design/rotating_bar_chain_kinematics_unit.sv
// Top level of the rotating bar chain kinematics unit: tables, sequencer and shared datapath.
`timescale 1ns / 1ps
// Sequence: a load word is written to its bar table when it is accepted. A tick holds the input,
//   plus output stalls, through the accept cycle, then per bar a prepare state, 14 CORDIC steps,
//   three multiply/accumulate states and an output state; on the last bar three squaring states
//   and 20 square root steps.
// Throughput: one tick at a time; the single CORDIC stage and the single multiplier set it.
// Reset: rst_ni clears all bar tables, the tick counter and the sequencer at once.
module rotating_bar_chain_kinematics_unit #(
  parameter int unsigned BAR_COUNT = 3
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input words
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        op_i,
  input  logic [2:0]  bar_slot_i,
  input  logic [14:0] bar_length_i,
  input  logic [15:0] start_angle_i,
  input  logic [15:0] phase_step_i,
  // result words
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [15:0] tick_number_o,
  output logic [2:0]  joint_slot_o,
  output logic [19:0] joint_x_o,
  output logic [19:0] joint_y_o,
  output logic [15:0] joint_angle_o,
  output logic [18:0] end_distance_o,
  output logic        last_o
);
  import rbc_kin_pkg::*;

  localparam int unsigned IdxW = (BAR_COUNT > 1) ? $clog2(BAR_COUNT) : 1;

  // bar tables and counters
  logic [14:0] len_q   [BAR_COUNT];
  logic [15:0] step_q  [BAR_COUNT];
  logic [15:0] angle_q [BAR_COUNT];
  logic [15:0] tick_q;

  state_e state_q, state_d;
  logic [IdxW-1:0] idx_q;
  logic [3:0]      iter_q;

  // CORDIC registers
  logic signed [18:0] cx_q, cy_q;
  logic signed [16:0] cz_q;
  logic               flip_q;
  logic [15:0]        ang_q;

  // accumulation and root registers
  logic signed [19:0] x_q, y_q;
  logic signed [41:0] prod_q;
  logic [39:0]        sq_q;
  logic [39:0]        rad_q;
  logic [39:0]        root_q;
  logic [39:0]        rbit_q;

  // combinational helpers
  logic               in_acc, out_acc, is_last, slot_ok;
  logic [15:0]        ang_new;
  logic               fold_hit;
  logic signed [18:0] dx, dy, cos_v, sin_v;
  logic signed [16:0] atan_v;
  logic signed [20:0] mul_a, mul_b;
  logic signed [41:0] prod_d, rnd_sum;
  logic signed [19:0] term;
  logic [39:0]        root_try;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = (state_q == ST_EMIT);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;
  assign is_last = (idx_q == IdxW'(BAR_COUNT - 1));
  assign slot_ok = ({1'b0, bar_slot_i} < 4'(BAR_COUNT));

  // advance the angle and fold it into a quarter turn either side of zero
  assign ang_new  = angle_q[idx_q] + step_q[idx_q];
  assign fold_hit = ($signed(ang_new) > 16'sd16384) || ($signed(ang_new) < -16'sd16384);

  // CORDIC micro-rotation terms
  assign dx     = cy_q >>> iter_q;
  assign dy     = cx_q >>> iter_q;
  assign atan_v = $signed({3'b000, atan_lut(iter_q)});

  // undo the half-turn fold
  assign cos_v = flip_q ? -cx_q : cx_q;
  assign sin_v = flip_q ? -cy_q : cy_q;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      ST_MULC: begin
        mul_a = $signed({6'b0, len_q[idx_q]});
        mul_b = {{2{cos_v[18]}}, cos_v};
      end
      ST_MULS: begin
        mul_a = $signed({6'b0, len_q[idx_q]});
        mul_b = {{2{sin_v[18]}}, sin_v};
      end
      ST_SQX: begin
        mul_a = {x_q[19], x_q};
        mul_b = {x_q[19], x_q};
      end
      ST_SQY: begin
        mul_a = {y_q[19], y_q};
        mul_b = {y_q[19], y_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_d  = mul_a * mul_b;
  assign rnd_sum = prod_q + RoundHalf;
  assign term    = rnd_sum[35:16];
  assign root_try = root_q + rbit_q;

  // sequencer next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc && (op_i == OpTick)) state_d = ST_PREP;
      ST_PREP: state_d = ST_ROT;
      ST_ROT:  if (iter_q == 4'(CordicSteps - 1)) state_d = ST_MULC;
      ST_MULC: state_d = ST_MULS;
      ST_MULS: state_d = ST_ACCS;
      ST_ACCS: state_d = is_last ? ST_SQX : ST_EMIT;
      ST_SQX:  state_d = ST_SQY;
      ST_SQY:  state_d = ST_SQS;
      ST_SQS:  state_d = ST_ROOT;
      ST_ROOT: if (rbit_q[0]) state_d = ST_EMIT;
      ST_EMIT: if (out_acc) state_d = is_last ? ST_IDLE : ST_PREP;
      default: state_d = ST_IDLE;
    endcase
  end

  // control state, tables and tick counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      iter_q  <= '0;
      tick_q  <= '0;
      for (int i = 0; i < BAR_COUNT; i++) begin
        len_q[i]   <= '0;
        step_q[i]  <= '0;
        angle_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      // load one bar
      if (in_acc && (op_i == OpLoad) && slot_ok) begin
        len_q[bar_slot_i[IdxW-1:0]]   <= bar_length_i;
        angle_q[bar_slot_i[IdxW-1:0]] <= start_angle_i;
        step_q[bar_slot_i[IdxW-1:0]]  <= phase_step_i;
      end
      if (in_acc && (op_i == OpTick)) idx_q <= '0;
      // store the advanced angle
      if (state_q == ST_PREP) begin
        angle_q[idx_q] <= ang_new;
        iter_q         <= '0;
      end
      if (state_q == ST_ROT) iter_q <= iter_q + 4'd1;
      // hand over to the next bar or finish the tick
      if (out_acc) begin
        if (is_last) tick_q <= tick_q + 16'd1;
        else idx_q <= idx_q + IdxW'(1);
      end
    end
  end

  // shared datapath registers
  always_ff @(posedge clk_i) begin
    if (in_acc && (op_i == OpTick)) begin
      x_q <= '0;
      y_q <= '0;
    end
    prod_q <= prod_d;
    case (state_q)
      ST_PREP: begin
        ang_q  <= ang_new;
        flip_q <= fold_hit;
        cx_q   <= CordicStart;
        cy_q   <= '0;
        cz_q   <= fold_hit ? $signed({~ang_new[15], ~ang_new[15], ang_new[14:0]})
                           : $signed({ang_new[15], ang_new});
      end
      ST_ROT: begin
        if (!cz_q[16]) begin
          cx_q <= cx_q - dx;
          cy_q <= cy_q + dy;
          cz_q <= cz_q - atan_v;
        end else begin
          cx_q <= cx_q + dx;
          cy_q <= cy_q - dy;
          cz_q <= cz_q + atan_v;
        end
      end
      ST_MULS: x_q <= x_q + term;
      ST_ACCS: y_q <= y_q + term;
      ST_SQY:  sq_q <= prod_q[39:0];
      ST_SQS: begin
        rad_q  <= sq_q + prod_q[39:0];
        root_q <= '0;
        rbit_q <= RootTop;
      end
      ST_ROOT: begin
        // one result bit per step
        if (rad_q >= root_try) begin
          rad_q  <= rad_q - root_try;
          root_q <= (root_q >> 1) + rbit_q;
        end else begin
          root_q <= root_q >> 1;
        end
        rbit_q <= rbit_q >> 2;
      end
      default: begin
      end
    endcase
  end

  // result word fields
  assign tick_number_o  = tick_q;
  assign joint_slot_o   = 3'(idx_q);
  assign joint_x_o      = x_q;
  assign joint_y_o      = y_q;
  assign joint_angle_o  = ang_q;
  assign end_distance_o = is_last ? root_q[18:0] : 19'd0;
  assign last_o         = is_last;

  // checks
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result word is pending");

  a_dist_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !last_o) |-> (end_distance_o == 19'd0))
    else $error("distance reported on a non-final word");

  a_tick_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && last_o)
      |=> (in_ready_o && tick_number_o == $past(tick_number_o) + 16'd1))
    else $error("tick did not finish after the final word");

  a_next_bar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_o) |=> (!in_ready_o && !out_valid_o))
    else $error("sequencer left the tick early");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the rotating bar chain kinematics unit.
`timescale 1ns / 1ps

module testbench;
  import rbc_kin_pkg::*;

  localparam int BarCount    = 3;
  localparam int TrigSteps   = 14;
  localparam int DrainCycles = BarCount * 19 + 40;
  localparam int HoldCycles  = 400;
  localparam int PlanLen     = 21;

  // One joint word as the unit reports it
  typedef struct packed {
    logic [15:0] tick;
    logic [2:0]  slot;
    logic [19:0] x;
    logic [19:0] y;
    logic [15:0] angle;
    logic [18:0] span;
    logic        last;
  } joint_t;

  // One row of the directed plan; pinned rows carry the end joint typed in
  typedef struct packed {
    logic        op;
    logic [2:0]  slot;
    logic [14:0] length;
    logic [15:0] start;
    logic [15:0] step;
    logic        pinned;
    logic [15:0] pin_angle;
    logic [19:0] pin_x;
    logic [19:0] pin_y;
    logic [18:0] pin_dist;
  } plan_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        op = OpLoad;
  logic [2:0]  bar_slot = '0;
  logic [14:0] bar_length = '0;
  logic [15:0] start_angle = '0;
  logic [15:0] phase_step = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] tick_number;
  logic [2:0]  joint_slot;
  logic [19:0] joint_x;
  logic [19:0] joint_y;
  logic [15:0] joint_angle;
  logic [18:0] end_distance;
  logic        joint_last;

  // Shadow copy of the bar tables and the tick counter
  logic [14:0] len_q   [BarCount];
  logic [15:0] step_q  [BarCount];
  logic [15:0] angle_q [BarCount];
  logic [15:0] tick_cnt;

  int atan_turns [TrigSteps] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1};

  joint_t joints_due[$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int hold_token  = 0;
  int holds_seen;
  int hold_left;
  int mismatch_cnt = 0;
  int words_checked = 0;
  int loads_sent = 0;
  int ticks_sent = 0;

  plan_row_t plan_rows [PlanLen] = '{
    // tick straight after reset: every bar is empty
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b1, 16'h0000, 20'd0, 20'd0, 19'd0},
    // loads to slots past the chain must leave it untouched
    '{OpLoad, 3'd3, 15'h7FFF, 16'h1234, 16'h0100, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd7, 15'h7FFF, 16'hFFFF, 16'hFFFF, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    // angle wraps from the top of the range to the bottom
    '{OpLoad, 3'd2, 15'h0000, 16'h7FFF, 16'h0001, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b1, 16'h8000, 20'd0, 20'd0, 19'd0},
    // full-length bars starting at zero, quarter and half turn
    '{OpLoad, 3'd0, 15'h7FFF, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd1, 15'h7FFF, 16'h4000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd2, 15'h7FFF, 16'h8000, 16'h8000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    // angles just past the quarter-turn fold on both sides, extreme steps
    '{OpLoad, 3'd0, 15'h0001, 16'h4001, 16'h7FFF, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd1, 15'h5555, 16'hC000, 16'hFFFF, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd2, 15'h2AAA, 16'hBFFF, 16'h4000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    // all bars aligned: longest reach of the chain
    '{OpLoad, 3'd0, 15'h7FFF, 16'h2000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd1, 15'h7FFF, 16'h2000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpLoad, 3'd2, 15'h7FFF, 16'h2000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    // fold the middle bar back into the third quadrant
    '{OpLoad, 3'd1, 15'h7FFF, 16'hA000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0},
    '{OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000, 1'b0, 16'h0, 20'd0, 20'd0, 19'd0}
  };

  rotating_bar_chain_kinematics_unit #(
    .BAR_COUNT(BarCount)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .op_i          (op),
    .bar_slot_i    (bar_slot),
    .bar_length_i  (bar_length),
    .start_angle_i (start_angle),
    .phase_step_i  (phase_step),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .tick_number_o (tick_number),
    .joint_slot_o  (joint_slot),
    .joint_x_o     (joint_x),
    .joint_y_o     (joint_y),
    .joint_angle_o (joint_angle),
    .end_distance_o(end_distance),
    .last_o        (joint_last)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sine and cosine of a turn-unit angle, 16 fraction bits
  function automatic void cordic_trig(input int ang, output int cos_v, output int sin_v);
    int  cx, cy, cz, dx, dy, i;
    bit  flip;
    flip = 1'b0;
    if (ang > 16384) begin
      ang -= 32768;
      flip = 1'b1;
    end else if (ang < -16384) begin
      ang += 32768;
      flip = 1'b1;
    end
    cx = int'(CordicStart);
    cy = 0;
    cz = ang;
    for (i = 0; i < TrigSteps; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (cz >= 0) begin
        cx -= dx;
        cy += dy;
        cz -= atan_turns[i];
      end else begin
        cx += dx;
        cy -= dy;
        cz += atan_turns[i];
      end
    end
    cos_v = flip ? -cx : cx;
    sin_v = flip ? -cy : cy;
  endfunction

  // Integer square root, rounded down
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Store one bar's settings; slots past the chain are dropped
  task automatic apply_load(input logic [2:0] slot_v, input logic [14:0] len_v,
                            input logic [15:0] ang_v, input logic [15:0] step_v);
    if (slot_v < BarCount) begin
      len_q[slot_v]   = len_v;
      angle_q[slot_v] = ang_v;
      step_q[slot_v]  = step_v;
    end
  endtask

  // Advance every angle, then walk the chain and queue one joint word per bar
  task automatic predict_tick();
    int              sx, sy, c, s, i;
    longint unsigned ax, ay, root;
    joint_t          j;
    sx = 0;
    sy = 0;
    for (i = 0; i < BarCount; i++) angle_q[i] = angle_q[i] + step_q[i];
    for (i = 0; i < BarCount; i++) begin
      cordic_trig(int'($signed(angle_q[i])), c, s);
      sx += int'((longint'(len_q[i]) * c + 32768) >>> 16);
      sy += int'((longint'(len_q[i]) * s + 32768) >>> 16);
      j.tick  = tick_cnt;
      j.slot  = i[2:0];
      j.x     = sx[19:0];
      j.y     = sy[19:0];
      j.angle = angle_q[i];
      j.last  = (i == BarCount - 1);
      j.span  = '0;
      if (j.last) begin
        ax     = (sx < 0) ? longint'(-sx) : longint'(sx);
        ay     = (sy < 0) ? longint'(-sy) : longint'(sy);
        root   = root_floor(ax * ax + ay * ay);
        j.span = root[18:0];
      end
      joints_due.push_back(j);
    end
    tick_cnt = tick_cnt + 16'd1;
  endtask

  // Offer one input word, hold it until taken, then update the prediction
  task automatic send_word(input logic op_v, input logic [2:0] slot_v,
                           input logic [14:0] len_v, input logic [15:0] ang_v,
                           input logic [15:0] step_v);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    op          <= op_v;
    bar_slot    <= slot_v;
    bar_length  <= len_v;
    start_angle <= ang_v;
    phase_step  <= step_v;
    do @(negedge clk_i); while (!in_ready);
    @(posedge clk_i);
    if (op_v == OpTick) begin
      ticks_sent++;
      predict_tick();
    end else begin
      loads_sent++;
      apply_load(slot_v, len_v, ang_v, step_v);
    end
  endtask

  // Draw one random word; mostly loads into live slots and ticks
  task automatic send_random(output bit counted);
    int          pick;
    logic [2:0]  slot_v;
    logic [14:0] len_v;
    logic [15:0] ang_v, step_v;
    pick = $urandom_range(99);
    if (pick < 40) begin
      send_word(OpTick, 3'($urandom_range(7)), 15'($urandom), 16'($urandom), 16'($urandom));
      counted = 1'b1;
    end else begin
      slot_v = (pick < 92) ? 3'($urandom_range(BarCount - 1))
                           : 3'($urandom_range(7, BarCount));
      case ($urandom_range(7))
        0:       len_v = 15'h0000;
        1:       len_v = 15'h7FFF;
        2:       len_v = 15'($urandom_range(255));
        default: len_v = 15'($urandom);
      endcase
      case ($urandom_range(5))
        0:       ang_v = 16'h8000;
        1:       ang_v = 16'h7FFF;
        2:       ang_v = $urandom_range(1) ? 16'h4000 : 16'hC000;
        default: ang_v = 16'($urandom);
      endcase
      case ($urandom_range(3))
        0:       step_v = 16'h0000;
        1:       step_v = 16'($urandom_range(511)) - 16'd256;
        default: step_v = 16'($urandom);
      endcase
      send_word(OpLoad, slot_v, len_v, ang_v, step_v);
      counted = (slot_v < BarCount);
    end
  endtask

  // Drive the output ready: random stalls, plus one long hold on request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready  <= 1'b0;
      hold_left  <= 0;
      holds_seen <= 0;
    end else if (holds_seen != hold_token) begin
      holds_seen <= hold_token;
      hold_left  <= HoldCycles;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  task automatic check_field(input string name, input longint want, input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare each taken joint word with the oldest prediction
  always @(negedge clk_i) begin
    joint_t j;
    if (rst_ni && out_valid && out_ready) begin
      if (joints_due.size() == 0) begin
        $error("joint word for slot %0d arrived with no prediction pending", joint_slot);
        mismatch_cnt++;
      end else begin
        j = joints_due.pop_front();
        check_field("tick_number", j.tick, tick_number);
        check_field("joint_slot", j.slot, joint_slot);
        check_field("joint_x", $signed(j.x), $signed(joint_x));
        check_field("joint_y", $signed(j.y), $signed(joint_y));
        check_field("joint_angle", $signed(j.angle), $signed(joint_angle));
        check_field("end_distance", j.span, end_distance);
        check_field("last", j.last, joint_last);
        words_checked++;
      end
    end
  end

  // Stimulus: directed plan, three random phases and a long output hold
  initial begin
    joint_t    j;
    plan_row_t row;
    int        n, i;
    bit        counted;
    for (i = 0; i < BarCount; i++) begin
      len_q[i]   = '0;
      step_q[i]  = '0;
      angle_q[i] = '0;
    end
    tick_cnt = '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan; pinned ticks take the typed end joint
    for (i = 0; i < PlanLen; i++) begin
      row = plan_rows[i];
      send_word(row.op, row.slot, row.length, row.start, row.step);
      if (row.op == OpTick && row.pinned) begin
        j       = joints_due.pop_back();
        j.angle = row.pin_angle;
        j.x     = row.pin_x;
        j.y     = row.pin_y;
        j.span  = row.pin_dist;
        joints_due.push_back(j);
      end
    end

    // Sender idles rarely, receiver often
    tx_idle_pct =  11;
    rx_idle_pct <= 54;
    n = 0;
    while (n < 110) begin
      send_random(counted);
      n += counted;
    end

    // Swap the idling sides
    tx_idle_pct =  54;
    rx_idle_pct <= 11;
    n = 0;
    while (n < 110) begin
      send_random(counted);
      n += counted;
    end

    // Hold the output off while ticks keep coming, so the input stalls
    tx_idle_pct =  0;
    rx_idle_pct <= 0;
    hold_token  <= hold_token + 1;
    repeat (6) send_word(OpTick, 3'd0, 15'h0000, 16'h0000, 16'h0000);

    // No idling at all
    n = 0;
    while (n < 74) begin
      send_random(counted);
      n += counted;
    end
    in_valid <= 1'b0;

    // Drain outstanding joint words, then give stray words a chance to show
    while (joints_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d bar loads and %0d ticks to a %0d-bar chain; checked %0d joint words.",
             loads_sent, ticks_sent, BarCount, words_checked);
    $display("Covered both idling mixes, back-to-back words and a %0d-cycle output hold.",
             HoldCycles);
    if (mismatch_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
